@@ src/sliding_window_maximum_top_macros.svh @@
// ---------------------------------------------------------------------------
// Sliding window maximum: assertion macros
// Clocked assertion helpers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_TOP_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_TOP_MACROS_SVH
`ifndef SYNTHESIS
// condition holds in the same cycle as the trigger
`define SWM_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);
// condition holds in the cycle after the trigger
`define SWM_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);
`else
`define SWM_ASSERT_SAME(lbl, trig, cond, msg)
`define SWM_ASSERT_NEXT(lbl, trig, cond, msg)
`endif
`endif

@@ src/swm_pkg.sv @@
// ---------------------------------------------------------------------------
// Sliding window maximum: package
// Shared constants and types.
// ---------------------------------------------------------------------------
package swm_pkg;

  localparam int CFG_BITS = 7;

  typedef logic [CFG_BITS-1:0] cfg_t;

  // per-transfer control broadcast to every cell
  typedef struct packed {
    logic shift;  // input transfer this cycle
    logic flush;  // stored sequence ended, stored candidates are stale
  } ctrl_t;

endpackage

@@ src/swm_cell.sv @@
// ---------------------------------------------------------------------------
// Sliding window maximum: candidate cell
// Holds one sample of the shift line and its candidate flag.
// ---------------------------------------------------------------------------
module swm_cell #(
  parameter int SAMPLE_BITS = 32,
  parameter int W_BITS      = 7,
  parameter int AGE         = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swm_pkg::ctrl_t                ctrl,
  input  logic        [W_BITS-1:0]      w,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] in_value,
  input  logic                          in_alive,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic                          alive,
  output logic                          fwd_alive
);
  import swm_pkg::*;

  // age of the incoming datum relative to the new sample
  localparam logic [W_BITS-1:0] AGE_V = W_BITS'(AGE);

  logic keep;

  // drop on expiry or when a strictly larger sample arrives
  assign keep      = in_alive && !(AGE_V >= w) && !(in_value < sample);
  assign fwd_alive = alive && !ctrl.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else if (ctrl.shift) begin
      alive <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= in_value;
    end
  end

endmodule

@@ src/swm_front.sv @@
// ---------------------------------------------------------------------------
// Sliding window maximum: front select
// Picks the value of the oldest live cell with a priority mux tree.
// ---------------------------------------------------------------------------
module swm_front #(
  parameter int SAMPLE_BITS = 32,
  parameter int CELLS       = 64
) (
  input  logic signed [SAMPLE_BITS-1:0] value [CELLS],
  input  logic                          alive [CELLS],
  output logic signed [SAMPLE_BITS-1:0] front
);
  import swm_pkg::*;

  localparam int LEAVES = 1 << $clog2(CELLS);

  logic signed [SAMPLE_BITS-1:0] node_value [1:2*LEAVES-1];
  logic                          node_alive [1:2*LEAVES-1];

  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < CELLS) begin
        node_value[LEAVES+i] = value[i];
        node_alive[LEAVES+i] = alive[i];
      end else begin
        node_value[LEAVES+i] = '0;
        node_alive[LEAVES+i] = 1'b0;
      end
    end
    // right child holds the older cells and wins when live
    for (int j = LEAVES - 1; j >= 1; j--) begin
      if (node_alive[2*j+1]) begin
        node_value[j] = node_value[2*j+1];
      end else begin
        node_value[j] = node_value[2*j];
      end
      node_alive[j] = node_alive[2*j+1] || node_alive[2*j];
    end
  end

  assign front = node_value[1];

endmodule

@@ src/sliding_window_maximum_top.sv @@
// ---------------------------------------------------------------------------
// Sliding window maximum: top level
// Monotonic candidate store as a shift line of cells plus front select.
// ---------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  -----------------------------
//  input    in_valid / in_stall    sample, last_sample
//  output   out_valid / out_stall  window_max
//  config   cfg_valid / cfg_ready  window_size
//
//  One sample per cycle is taken while in_stall is low; a result passes
//  from the cell update through the front-select tree into the output
//  register. The tree depth, log2(WINDOW_MAX) mux levels, sets the path.
//  Reset is synchronous and clears cell flags, fill level and both stages.
//  in_stall rises only while a result waits in the middle stage and the
//  output register is held by out_stall.
//
`include "sliding_window_maximum_top_macros.svh"

module sliding_window_maximum_top #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last_sample,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] window_max,
  // window length register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  swm_pkg::cfg_t                 window_size
);
  import swm_pkg::*;

  localparam int W_BITS   = $clog2(WINDOW_MAX + 1);
  localparam int CMP_BITS = (CFG_BITS > W_BITS) ? CFG_BITS : W_BITS;

  // window length register and its clamped form
  cfg_t                win_reg;
  logic [CMP_BITS-1:0] win_wide;
  logic [W_BITS-1:0]   w;

  // sequence state
  logic              flush;      // last sample seen; stored state is stale
  logic [W_BITS-1:0] fill;
  logic [W_BITS-1:0] fill_eff;
  logic [W_BITS-1:0] fill_next;
  logic              has_result;

  // handshake
  logic  in_xfer;
  logic  pend_valid;   // result waiting for the front select
  logic  pend_move;
  ctrl_t ctrl;

  // cell row
  logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
  logic                          cell_alive [WINDOW_MAX];
  logic                          cell_fwd   [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] front;

  // ---- configuration: always ready; the user must write it only while idle, unchecked here ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg <= cfg_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      win_reg <= window_size;
    end
  end

  // zero counts as one, anything above the built depth as the depth
  assign win_wide = CMP_BITS'(win_reg);
  always_comb begin
    if (win_reg == '0) begin
      w = W_BITS'(1);
    end else if (win_wide > CMP_BITS'(WINDOW_MAX)) begin
      w = W_BITS'(WINDOW_MAX);
    end else begin
      w = W_BITS'(win_wide);
    end
  end

  // ---- handshake ----
  // middle stage drains into the output register when that is free
  assign pend_move = pend_valid && !(out_valid && out_stall);
  assign in_stall  = pend_valid && !pend_move;
  assign in_xfer   = in_valid && !in_stall;

  assign ctrl.shift = in_xfer;
  assign ctrl.flush = flush;

  // ---- fill level, cleared lazily after a last sample ----
  assign fill_eff   = flush ? '0 : fill;
  assign fill_next  = (fill_eff < W_BITS'(WINDOW_MAX)) ? fill_eff + W_BITS'(1) : fill_eff;
  assign has_result = fill_next >= w;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      flush <= 1'b0;
    end else if (in_xfer) begin
      fill  <= fill_next;
      flush <= last_sample;
    end
  end

  // ---- cell row: cell k takes the datum of age k relative to the new sample ----
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      swm_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .W_BITS      (W_BITS),
        .AGE         (k)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .w         (w),
        .sample    (sample),
        .in_value  (sample),
        .in_alive  (1'b1),
        .value     (cell_value[k]),
        .alive     (cell_alive[k]),
        .fwd_alive (cell_fwd[k])
      );
    end else begin : g_body
      swm_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .W_BITS      (W_BITS),
        .AGE         (k)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .w         (w),
        .sample    (sample),
        .in_value  (cell_value[k-1]),
        .in_alive  (cell_fwd[k-1]),
        .value     (cell_value[k]),
        .alive     (cell_alive[k]),
        .fwd_alive (cell_fwd[k])
      );
    end
  end

  // oldest live cell is the window maximum
  swm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CELLS       (WINDOW_MAX)
  ) u_front (
    .value (cell_value),
    .alive (cell_alive),
    .front (front)
  );

  // ---- result stages ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_xfer) begin
      pend_valid <= has_result;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      window_max <= front;
    end
  end

  // ---- checks ----
  `SWM_ASSERT_NEXT(a_head_live, in_xfer, cell_alive[0], "newest sample not kept as candidate")
  `SWM_ASSERT_NEXT(a_drain, pend_move, out_valid, "pending result lost on its way out")
  `SWM_ASSERT_NEXT(a_result, in_xfer && has_result, pend_valid, "result not queued after transfer")
  `SWM_ASSERT_SAME(a_fill_cap, !flush, fill <= W_BITS'(WINDOW_MAX), "fill level beyond depth")

endmodule
